FILE: src/sdpap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpap_pkg
// Types, constants and helper functions shared by the SDP answer audio parser.
// ----------------------------------------------------------------------------
package sdpap_pkg;

   typedef struct packed {
      logic [7:0] sdp_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] remote_address;
      logic [15:0] remote_port;
      logic [6:0]  event_payload;
   } rsp_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NO_C    = 3'd1;
   localparam logic [2:0] ST_NO_M    = 3'd2;
   localparam logic [2:0] ST_BAD_PRT = 3'd3;
   localparam logic [2:0] ST_NO_PCMU = 3'd4;

   localparam logic [6:0] EVENT_RESET = 7'd101;

   localparam int unsigned NUM_PREFIXES = 4;
   localparam int unsigned EVENT_LEN    = 15;

   localparam logic [4:0] PREFIX_LEN [NUM_PREFIXES] = '{5'd9, 5'd8, 5'd15, 5'd9};

   // prefix characters, index 0 is the first character
   function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [3:0] col);
      logic [8*15-1:0] s;
      begin
         unique case (k)
            2'd0:    s = {"c=IN IP4 ", 48'h0};
            2'd1:    s = {"m=audio ", 56'h0};
            2'd2:    s = "a=rtpmap:0 PCMU";
            default: s = {"a=rtpmap:", 48'h0};
         endcase
         prefix_char = s[8*(14-col) +: 8];
      end
   endfunction

   function automatic logic [7:0] event_char(input logic [3:0] idx);
      logic [8*15-1:0] s;
      begin
         s = "telephone-event";
         event_char = (idx < 4'd15) ? s[8*(14-idx) +: 8] : 8'h00;
      end
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
              (b == 8'h0C) || (b == 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = (b >= 8'h30) && (b <= 8'h39);
   endfunction

endpackage

FILE: src/sdp_answer_audio_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_answer_audio_parser_unit
// Byte-serial SDP answer scanner: address, audio port, PCMU, event type.
// ----------------------------------------------------------------------------
//  channel  direction  payload   handshake
//  req      in         req_type  req_valid / req_ready
//  rsp      out        rsp_type  rsp_valid / rsp_ready
//  csr      in         7 bits    csr_write, no wait
//
// One byte is taken per cycle while req_ready is high; scan state updates
// from the input register. The marked last byte registers one response from
// there in the output register; req_ready stays high unless that register
// holds an untaken response and another last byte would replace it.
// Synchronous active-high reset returns scan state and the register default.
module sdp_answer_audio_parser_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sdpap_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sdpap_pkg::rsp_type  rsp_data,
   input  logic                csr_write,
   input  logic [6:0]          csr_data
);
   import sdpap_pkg::*;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_T = 8'h74;

   // input register
   logic       in_vld_ff;
   req_type    in_ff;

   logic [6:0] dflt_ff, dflt_in;
   logic [4:0] column_ff, column_in;
   logic [3:0] alive_ff, alive_in;
   logic [1:0] aphase_ff, aphase_in;
   logic [31:0] aword_ff, aword_in;
   logic [8:0] oacc_ff, oacc_in;
   logic [1:0] oidx_ff, oidx_in;
   logic       abad_ff, abad_in, odig_ff, odig_in;
   logic [1:0] mphase_ff, mphase_in;
   logic [16:0] pacc_ff, pacc_in;
   logic       pneg_ff, pneg_in, pscan_ff, pscan_in, pseen_ff, pseen_in;
   logic [15:0] recent_ff, recent_in;
   logic [1:0] map_ff, map_in;
   logic [6:0] mtype_ff, mtype_in;
   logic [3:0] ematch_ff, ematch_in;
   logic [6:0] etype_ff, etype_in;
   logic       enamed_ff, enamed_in;

   logic       out_vld_ff, out_vld_in;
   rsp_type    out_ff, out_in;

   // a last byte in the input register needs the output register free
   logic stall;
   assign stall     = in_vld_ff && in_ff.last_byte && out_vld_ff && !rsp_ready;
   assign req_ready = !stall;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic [7:0] b;
      logic       do_step;
      logic [3:0] nz;
      logic [15:0] low;
      logic [10:0] mv;
      logic [11:0] ov;
      logic [2:0] st;
      b = in_ff.sdp_byte;
      do_step = in_vld_ff && !stall;

      dflt_in = csr_write ? csr_data : dflt_ff;
      column_in = column_ff; alive_in = alive_ff; aphase_in = aphase_ff;
      aword_in = aword_ff; oacc_in = oacc_ff; oidx_in = oidx_ff;
      abad_in = abad_ff; odig_in = odig_ff; mphase_in = mphase_ff;
      pacc_in = pacc_ff; pneg_in = pneg_ff; pscan_in = pscan_ff;
      pseen_in = pseen_ff; recent_in = recent_ff; map_in = map_ff;
      mtype_in = mtype_ff; ematch_in = ematch_ff; etype_in = etype_ff;
      enamed_in = enamed_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      nz = '0; low = '0; mv = '0; ov = '0; st = ST_OK;

      if (csr_write && !enamed_ff) etype_in = csr_data;

      if (do_step) begin
         // address
         if (aphase_ff == 2'd1) begin
            if (b == CH_CR || b == CH_LF || b == CH_SP || b == CH_TAB) begin
               aword_in = (!abad_ff && oidx_ff == 2'd3 && odig_ff) ?
                          {aword_ff[23:0], oacc_ff[7:0]} : 32'hFFFF_FFFF;
               aphase_in = 2'd2;
            end else if (!abad_ff) begin
               if (is_digit(b)) begin
                  ov = {3'd0, oacc_ff} * 12'd10 + {8'd0, b[3:0]};
                  odig_in = 1'b1;
                  if (ov > 12'd255) begin
                     abad_in = 1'b1; oacc_in = 9'd256;
                  end else begin
                     oacc_in = ov[8:0];
                  end
               end else if (b == CH_DOT) begin
                  if (!odig_ff || oidx_ff == 2'd3) abad_in = 1'b1;
                  else begin
                     aword_in = {aword_ff[23:0], oacc_ff[7:0]};
                     oidx_in = oidx_ff + 2'd1; oacc_in = '0; odig_in = 1'b0;
                  end
               end else begin
                  abad_in = 1'b1;
               end
            end
         end
         // port: phase 1 skip, 2 digits, 3 done
         low = pacc_ff[15:0] * 16'd10 + {12'd0, b[3:0]};
         if (mphase_ff == 2'd1) begin
            if (!is_ws(b)) begin
               if (b == CH_PLUS) mphase_in = 2'd2;
               else if (b == CH_MINUS) begin pneg_in = 1'b1; mphase_in = 2'd2; end
               else if (is_digit(b)) begin
                  pacc_in = {pacc_ff[16] | (b != CH_ZERO), low}; mphase_in = 2'd2;
               end else mphase_in = 2'd3;
            end
         end else if (mphase_ff == 2'd2) begin
            if (is_digit(b)) pacc_in = {pacc_ff[16] | (b != CH_ZERO), low};
            else mphase_in = 2'd3;
         end
         // pcmu token on the m line
         if (pscan_ff) begin
            if (recent_ff == {CH_SP, CH_ZERO} && (b == CH_SP || b == CH_CR || b == CH_LF))
               pseen_in = 1'b1;
            if (b == CH_CR || b == CH_LF) pscan_in = 1'b0;
            recent_in = {recent_ff[7:0], b};
         end
         // rtpmap line
         if (map_ff != 2'd0 && b != CH_LF) begin
            if (map_ff == 2'd1) begin
               if (!is_ws(b)) begin
                  if (b == CH_PLUS) map_in = 2'd2;
                  else if (b == CH_MINUS) begin mtype_in = '0; map_in = 2'd3; end
                  else if (is_digit(b)) begin mtype_in = {3'd0, b[3:0]}; map_in = 2'd2; end
                  else map_in = 2'd3;
               end
            end else if (map_ff == 2'd2) begin
               if (is_digit(b)) begin
                  mv = {4'd0, mtype_ff} * 11'd10 + {7'd0, b[3:0]};
                  mtype_in = (mv > 11'd127) ? 7'd127 : mv[6:0];
               end else map_in = 2'd3;
            end
            if (ematch_ff < 4'(EVENT_LEN)) begin
               if (b == event_char(ematch_ff)) ematch_in = ematch_ff + 4'd1;
               else ematch_in = (b == CH_T) ? 4'd1 : 4'd0;
               if (ematch_in == 4'(EVENT_LEN) && mtype_in != 7'd0) begin
                  etype_in = mtype_in; enamed_in = 1'b1;
               end
            end
         end
         // line prefixes
         if (b == CH_LF) begin
            column_in = '0; alive_in = 4'hF; map_in = 2'd0; ematch_in = '0;
         end else begin
            for (int k = 0; k < NUM_PREFIXES; k++) begin
               if (alive_ff[k] && column_ff < PREFIX_LEN[k]) begin
                  if (b != prefix_char(2'(k), column_ff[3:0])) alive_in[k] = 1'b0;
                  else if (column_ff == PREFIX_LEN[k] - 5'd1) begin
                     alive_in[k] = 1'b0;
                     nz[k] = 1'b1;
                  end
               end
            end
            if (nz[0] && aphase_ff == 2'd0) begin
               aphase_in = 2'd1; aword_in = '0; oacc_in = '0; oidx_in = '0;
               abad_in = 1'b0; odig_in = 1'b0;
            end
            if (nz[1] && mphase_ff == 2'd0) begin
               mphase_in = 2'd1; pscan_in = 1'b1; recent_in = '0;
            end
            if (nz[2]) pseen_in = 1'b1;
            if (nz[3]) begin map_in = 2'd1; mtype_in = '0; ematch_in = '0; end
            if (column_ff != 5'd31) column_in = column_ff + 5'd1;
         end

         if (in_ff.last_byte) begin
            if (aphase_in == 2'd1)
               aword_in = (!abad_in && oidx_in == 2'd3 && odig_in) ?
                          {aword_in[23:0], oacc_in[7:0]} : 32'hFFFF_FFFF;
            if (pscan_in && recent_in == {CH_SP, CH_ZERO}) pseen_in = 1'b1;
            priority if (aphase_in == 2'd0) st = ST_NO_C;
            else if (mphase_in == 2'd0) st = ST_NO_M;
            else if (!pacc_in[16] || pneg_in) st = ST_BAD_PRT;
            else if (!pseen_in) st = ST_NO_PCMU;
            else st = ST_OK;
            out_vld_in = 1'b1;
            out_in.status = st;
            if (st == ST_OK) begin
               out_in.remote_address = aword_in;
               out_in.remote_port = pacc_in[15:0];
               out_in.event_payload = enamed_in ? etype_in : dflt_in;
            end else begin
               out_in.remote_address = '0; out_in.remote_port = '0;
               out_in.event_payload = '0;
            end
            column_in = '0; alive_in = 4'hF; aphase_in = '0; aword_in = '0;
            oacc_in = '0; oidx_in = '0; abad_in = 1'b0; odig_in = 1'b0;
            mphase_in = '0; pacc_in = '0; pneg_in = 1'b0; pscan_in = 1'b0;
            pseen_in = 1'b0; recent_in = '0; map_in = '0; mtype_in = '0;
            ematch_in = '0; etype_in = dflt_in; enamed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) in_ff <= req_data;
      out_ff <= out_in;
      if (reset) begin
         in_vld_ff <= 1'b0; out_vld_ff <= 1'b0; dflt_ff <= EVENT_RESET;
         column_ff <= '0; alive_ff <= 4'hF; aphase_ff <= '0; oidx_ff <= '0;
         abad_ff <= 1'b0; odig_ff <= 1'b0; mphase_ff <= '0; pneg_ff <= 1'b0;
         pscan_ff <= 1'b0; pseen_ff <= 1'b0; map_ff <= '0; ematch_ff <= '0;
         etype_ff <= EVENT_RESET; enamed_ff <= 1'b0;
         aword_ff <= '0; oacc_ff <= '0; pacc_ff <= '0; recent_ff <= '0; mtype_ff <= '0;
      end else begin
         if (req_ready) in_vld_ff <= req_valid;
         out_vld_ff <= out_vld_in; dflt_ff <= dflt_in;
         column_ff <= column_in; alive_ff <= alive_in; aphase_ff <= aphase_in;
         oidx_ff <= oidx_in; abad_ff <= abad_in; odig_ff <= odig_in;
         mphase_ff <= mphase_in; pneg_ff <= pneg_in; pscan_ff <= pscan_in;
         pseen_ff <= pseen_in; map_ff <= map_in; ematch_ff <= ematch_in;
         etype_ff <= etype_in; enamed_ff <= enamed_in;
         aword_ff <= aword_in; oacc_ff <= oacc_in; pacc_ff <= pacc_in;
         recent_ff <= recent_in; mtype_ff <= mtype_in;
      end
   end

endmodule
